[rtl/ppmdec_pkg.sv]
// Package: shared constants and types for the PPM frame channel decoder.
`timescale 1ns / 1ps

package ppmdec_pkg;

   // Default parameter values
   localparam int NUM_CHANNELS_DEFAULT = 10;
   localparam int COUNTER_BITS_DEFAULT = 16;

   // Fixed field widths
   localparam int WIDTH_BITS   = 16;
   localparam int CHANNEL_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register reset values
   localparam logic [WIDTH_BITS-1:0] SYNC_THRESHOLD_RESET = 16'd2100;
   localparam logic [WIDTH_BITS-1:0] TIMER_PERIOD_RESET   = 16'd65535;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SYNC_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TIMER_PERIOD   = 2'd1;

   // One result transaction
   typedef struct packed {
      logic                    width_valid;
      logic [CHANNEL_BITS-1:0] channel_number;
      logic [WIDTH_BITS-1:0]   pulse_width;
      logic                    frame_resync;
      logic                    counter_overflow;
   } result_type;

endpackage

[rtl/ppm_frame_channel_decoder_top.sv]
// Top level: PPM frame channel decoder with tick counter and output skid buffer.
`timescale 1ns / 1ps

// PPM frame channel decoder.
// Each request transaction is one timer tick; req_edge_seen flags a captured PPM
// edge in that tick. An internal tick counter wraps at timer_period; on each
// edge but the first of a frame the block returns the tick count since the
// previous edge with a zero-based channel number, and a width above
// sync_threshold restarts the frame. Every request gives exactly one response
// transaction, registered in the result register and presented on rsp_*;
// one transaction per cycle while req_ready is high, set by the single pass
// of decode logic between the counter/pointer registers and the result
// register. When the receiver stalls, one further transaction is parked in
// a skid register; req_ready then drops until the held response is taken.
// Reset (synchronous, active high) clears the counter, the previous edge time
// and the channel pointer (waiting for the first edge), empties the response
// path and loads the register defaults (sync_threshold 2100, timer_period
// 65535). CSR writes through csr_write_enable/csr_index/csr_write_data take
// effect at the next clock edge; indexes beyond timer_period are ignored.
module ppm_frame_channel_decoder_top #(
   parameter int NUM_CHANNELS = ppmdec_pkg::NUM_CHANNELS_DEFAULT,
   parameter int COUNTER_BITS = ppmdec_pkg::COUNTER_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request channel
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_edge_seen,
   // response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_width_valid,
   output logic [ppmdec_pkg::CHANNEL_BITS-1:0]    rsp_channel_number,
   output logic [ppmdec_pkg::WIDTH_BITS-1:0]      rsp_pulse_width,
   output logic                                   rsp_frame_resync,
   output logic                                   rsp_counter_overflow,
   // configuration write port
   input  logic                                   csr_write_enable,
   input  logic [ppmdec_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppmdec_pkg::CSR_DATA_BITS-1:0]   csr_write_data
);

   localparam int WB   = ppmdec_pkg::WIDTH_BITS;
   localparam int CB   = ppmdec_pkg::CHANNEL_BITS;
   localparam int EXTW = (COUNTER_BITS > WB) ? COUNTER_BITS : WB;

   // configuration registers
   logic [WB-1:0] sync_threshold_ff, sync_threshold_in;
   logic [WB-1:0] timer_period_ff, timer_period_in;

   // decoder state
   logic [COUNTER_BITS-1:0] tick_count_ff, tick_count_in;
   logic [WB-1:0]           prev_edge_ff, prev_edge_in;
   logic [CB-1:0]           chan_ptr_ff, chan_ptr_in;

   // response path
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   ppmdec_pkg::result_type rsp_data_ff, rsp_data_in;
   ppmdec_pkg::result_type skid_data_ff, skid_data_in;
   ppmdec_pkg::result_type result;

   logic            req_fire, rsp_fire;
   logic [EXTW-1:0] now_ext;
   logic [WB-1:0]   stamp, width;
   logic            wrap;
   logic [CB-1:0]   ptr_after_wrap;
   logic [CB:0]     ptr_inc;

   assign req_ready = !skid_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // CSR writes
   always_comb begin
      sync_threshold_in = sync_threshold_ff;
      timer_period_in   = timer_period_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ppmdec_pkg::CSR_SYNC_THRESHOLD: sync_threshold_in = csr_write_data;
            ppmdec_pkg::CSR_TIMER_PERIOD:   timer_period_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   // tick decode: wrap first, then the edge
   assign now_ext        = EXTW'(tick_count_ff);
   assign stamp          = now_ext[WB-1:0];
   assign width          = stamp - prev_edge_ff;
   assign wrap           = now_ext >= EXTW'(timer_period_ff);
   assign ptr_after_wrap = wrap ? '0 : chan_ptr_ff;
   assign ptr_inc        = {1'b0, ptr_after_wrap} + (CB+1)'(1);

   always_comb begin
      result        = '0;
      tick_count_in = tick_count_ff;
      prev_edge_in  = prev_edge_ff;
      chan_ptr_in   = chan_ptr_ff;
      if (req_fire) begin
         result.counter_overflow = wrap;
         tick_count_in = wrap ? '0 : tick_count_ff + COUNTER_BITS'(1);
         chan_ptr_in   = ptr_after_wrap;
         if (req_edge_seen) begin
            if (ptr_after_wrap == '0) begin
               // first edge of a frame
               tick_count_in = '0;
               prev_edge_in  = '0;
               chan_ptr_in   = CB'(1);
            end else begin
               result.width_valid    = 1'b1;
               result.channel_number = ptr_after_wrap - CB'(1);
               result.pulse_width    = width;
               prev_edge_in          = stamp;
               if (width > sync_threshold_ff) begin
                  // frame sync gap
                  result.frame_resync = 1'b1;
                  tick_count_in       = '0;
                  prev_edge_in        = '0;
                  chan_ptr_in         = CB'(1);
               end else if (ptr_inc > (CB+1)'(NUM_CHANNELS)) begin
                  chan_ptr_in = '0;
               end else begin
                  chan_ptr_in = ptr_inc[CB-1:0];
               end
            end
         end
      end
   end

   // response register with one skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_fire) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (req_fire) begin
         if (!rsp_valid_ff || rsp_fire) begin
            rsp_data_in  = result;
            rsp_valid_in = 1'b1;
         end else begin
            skid_data_in  = result;
            skid_valid_in = 1'b1;
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_threshold_ff <= ppmdec_pkg::SYNC_THRESHOLD_RESET;
         timer_period_ff   <= ppmdec_pkg::TIMER_PERIOD_RESET;
         tick_count_ff     <= '0;
         prev_edge_ff      <= '0;
         chan_ptr_ff       <= '0;
         rsp_valid_ff      <= 1'b0;
         skid_valid_ff     <= 1'b0;
      end else begin
         sync_threshold_ff <= sync_threshold_in;
         timer_period_ff   <= timer_period_in;
         tick_count_ff     <= tick_count_in;
         prev_edge_ff      <= prev_edge_in;
         chan_ptr_ff       <= chan_ptr_in;
         rsp_valid_ff      <= rsp_valid_in;
         skid_valid_ff     <= skid_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_width_valid      = rsp_data_ff.width_valid;
   assign rsp_channel_number   = rsp_data_ff.channel_number;
   assign rsp_pulse_width      = rsp_data_ff.pulse_width;
   assign rsp_frame_resync     = rsp_data_ff.frame_resync;
   assign rsp_counter_overflow = rsp_data_ff.counter_overflow;

   // channel pointer stays within the frame
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      chan_ptr_ff <= CB'(NUM_CHANNELS))
      else $error("channel pointer beyond last channel");

   // skid entry only ever backs up a held response
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty response register");

   // a transaction taken during a stall lands in the skid entry
   a_stall_to_skid: assert property (@(posedge clock) disable iff (reset)
      (req_fire && rsp_valid_ff && !rsp_ready) |=> skid_valid_ff)
      else $error("stalled transaction not parked");

   // a response without a width carries zero channel, width and resync fields
   a_no_width_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.width_valid) |->
         (rsp_data_ff.channel_number == '0 && rsp_data_ff.pulse_width == '0 &&
          !rsp_data_ff.frame_resync))
      else $error("response without width has nonzero fields");

   // frame sync rewinds the counter and re-arms the first channel
   a_resync_rearm: assert property (@(posedge clock) disable iff (reset)
      (req_fire && result.frame_resync) |=>
         (tick_count_ff == '0 && prev_edge_ff == '0 && chan_ptr_ff == CB'(1)))
      else $error("frame sync did not re-arm");

endmodule
